// ----- rtl/bsr_pkg.sv -----
// Types and status codes shared by the byte stream reassembler modules.
// No dependencies.
`default_nettype none

package bsr_pkg;

  // Result status codes
  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_OUTSIDE = 3'd2;
  localparam logic [2:0] ST_PULLED  = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  // Request mode
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  byte_value;
    logic [31:0] stream_index;
    logic        has_byte;
    logic        end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [12:0] pending_count;
    logic        stream_done;
  } out_item_t;

  // One window entry: presence flag and the stored byte
  typedef struct packed {
    logic       present;
    logic [7:0] data;
  } entry_t;

endpackage

`default_nettype wire

// ----- rtl/bsr_window_mem.sv -----
// Window memory: one write port, one read port, registered read data.
// Depends on bsr_pkg for the entry type.
`default_nettype none

module bsr_window_mem
  import bsr_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bsr_out_reg.sv -----
// Result register between the evaluation stage and the result channel.
// Depends on bsr_pkg for the result type.
`default_nettype none

module bsr_out_reg
  import bsr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire out_item_t load_data,
  output logic           free,
  output logic           valid,
  input  wire logic      ready,
  output out_item_t      data
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/byte_stream_reassembler.sv -----
// Byte stream reassembler. Pushes store a byte at its absolute stream index in a circular
// window of WINDOW_DEPTH entries held in one synchronous memory ({present, byte} per entry);
// pulls hand out the byte at the next expected index when it is there. Every transaction
// on the item channel gives exactly one transaction on the result channel. An item passes
// through accept, address calculation with the memory read, then evaluation with the write
// back into the window and the result register load; the single memory port pair and its
// registered read set these steps, and a held result register stalls evaluation. A new item
// is taken only once the last is through. After reset the block sweeps the window clearing
// every presence flag, one entry per cycle, and item_ready stays low until the sweep ends.
// Depends on bsr_pkg, bsr_window_mem and bsr_out_reg.
`default_nettype none

module byte_stream_reassembler
  import bsr_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4096
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  output logic          item_ready,
  input  wire in_item_t item,
  output logic          result_valid,
  input  wire logic     result_ready,
  output out_item_t     result
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(WINDOW_DEPTH);
  localparam logic [31:0]   DEPTH_32  = 32'(WINDOW_DEPTH);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_CALC  = 2'd2;
  localparam logic [1:0] S_EVAL  = 2'd3;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [AW-1:0] clear_addr;
  in_item_t      req;
  logic [31:0]   offset;
  logic          outside;
  logic [AW-1:0] slot;

  logic [31:0]   next_index;
  logic [31:0]   next_index_next;
  logic [AW-1:0] read_slot;
  logic [AW-1:0] read_slot_next;
  logic [CW-1:0] stored_count;
  logic [CW-1:0] stored_count_next;
  logic          end_known;
  logic          end_known_next;
  logic [31:0]   end_gap;          // end position minus next_index
  logic [31:0]   end_gap_next;

  // Address calculation
  logic [31:0]   offset_c;
  logic          outside_c;
  logic [AW:0]   slot_sum;
  logic [AW-1:0] slot_c;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  entry_t        rd_data;

  // Evaluation
  logic          fire;
  logic          out_free;
  logic          wr_req;
  entry_t        wr_req_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;
  out_item_t     res_c;
  logic          done_now;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    offset_c  = req.stream_index - next_index;
    outside_c = (offset_c >= DEPTH_32) || (end_known && (offset_c >= end_gap));
    slot_sum  = {1'b0, read_slot} + {1'b0, offset_c[AW-1:0]};
    if (slot_sum >= DEPTH_W) begin
      slot_c = AW'(slot_sum - DEPTH_W);
    end else begin
      slot_c = slot_sum[AW-1:0];
    end
    rd_addr = (req.mode == MODE_PULL) ? read_slot : slot_c;
    rd_en   = (state == S_CALC);
  end

  assign done_now = end_known && (end_gap == 32'd0);
  assign fire     = (state == S_EVAL) && out_free;

  always_comb begin
    res_c             = '0;
    res_c.status      = ST_STORED;
    wr_req            = 1'b0;
    wr_req_data       = rd_data;
    next_index_next   = next_index;
    read_slot_next    = read_slot;
    stored_count_next = stored_count;
    end_known_next    = end_known;
    end_gap_next      = end_gap;
    if (req.mode == MODE_PUSH) begin
      if (req.has_byte) begin
        if (outside) begin
          res_c.status = ST_OUTSIDE;
        end else if (rd_data.present) begin
          res_c.status = ST_DUP;
        end else begin
          wr_req            = 1'b1;
          wr_req_data       = '{present: 1'b1, data: req.byte_value};
          stored_count_next = stored_count + CW'(1);
        end
      end
      // Keep the first end position; a byte-carried end lies one past the byte
      if (req.end_of_stream && !end_known) begin
        end_known_next = 1'b1;
        end_gap_next   = offset + {31'd0, req.has_byte};
      end
    end else begin
      if (!done_now && rd_data.present) begin
        res_c.status      = ST_PULLED;
        res_c.out_valid   = 1'b1;
        res_c.out_byte    = rd_data.data;
        wr_req            = 1'b1;
        wr_req_data       = '{present: 1'b0, data: rd_data.data};
        read_slot_next    = (read_slot == LAST_SLOT) ? '0 : read_slot + AW'(1);
        next_index_next   = next_index + 32'd1;
        end_gap_next      = end_gap - 32'd1;
        if (stored_count != '0) begin
          stored_count_next = stored_count - CW'(1);
        end
      end else begin
        res_c.status = ST_EMPTY;
      end
    end
    res_c.pending_count = 13'(stored_count_next);
    res_c.stream_done   = end_known_next && (end_gap_next == 32'd0);
  end

  // Clearing sweep has the write port to itself
  always_comb begin
    if (state == S_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clear_addr;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = fire && wr_req;
      mem_wr_addr = slot;
      mem_wr_data = wr_req_data;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clear_addr == LAST_SLOT) state_next = S_IDLE;
      S_IDLE:  if (item_valid) state_next = S_CALC;
      S_CALC:  state_next = S_EVAL;
      S_EVAL:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clear_addr   <= '0;
      next_index   <= '0;
      read_slot    <= '0;
      stored_count <= '0;
      end_known    <= 1'b0;
      end_gap      <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clear_addr <= clear_addr + AW'(1);
      end
      if (fire) begin
        next_index   <= next_index_next;
        read_slot    <= read_slot_next;
        stored_count <= stored_count_next;
        end_known    <= end_known_next;
        end_gap      <= end_gap_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      req <= item;
    end
    if (state == S_CALC) begin
      offset  <= offset_c;
      outside <= outside_c;
      slot    <= rd_addr;
    end
  end

  bsr_window_mem #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bsr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .load_data (res_c),
    .free      (out_free),
    .valid     (result_valid),
    .ready     (result_ready),
    .data      (result)
  );

endmodule

`default_nettype wire

// ----- rtl/bsr_checker.sv -----
// Port-level checks for byte_stream_reassembler, attached by the bind below.
// Depends on bsr_pkg for the item types and status codes.
`default_nettype none

module bsr_checker
  import bsr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      item_valid,
  input wire logic      item_ready,
  input wire in_item_t  item,
  input wire logic      result_valid,
  input wire logic      result_ready,
  input wire out_item_t result
);

  // Clearing sweep follows every reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !item_ready)
    else $error("item_ready high straight after reset");

  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_ready) |=> (item_valid && $stable(item)))
    else $error("waiting item transaction changed");

  a_valid_with_pull: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.out_valid == (result.status == ST_PULLED)))
    else $error("out_valid does not match pulled status");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.out_valid) |-> (result.out_byte == 8'd0))
    else $error("out_byte set without a pulled byte");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result transaction changed");

endmodule

bind byte_stream_reassembler bsr_checker u_bsr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

`default_nettype wire

// ----- bench/bsr_stream_checker.sv -----
// Checker for the byte stream reassembler: watches both channels, predicts each result
// from the accepted items and compares it with what the block returns.
// Depends on bsr_pkg for the item, result and status definitions.
module bsr_stream_checker
  import bsr_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      item_ready,
  input  in_item_t  item,
  input  logic      result_valid,
  input  logic      result_ready,
  input  out_item_t result,
  output int        errors,
  output int        outstanding,
  output int        n_checked,
  output int        n_pulled,
  output int        n_dropped,
  output logic      done_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the reorder window and its read point
  logic [7:0]  win_data [WINDOW_DEPTH];
  bit          win_full [WINDOW_DEPTH];
  logic [31:0] rd_index = '0;
  int unsigned rd_slot = 0;
  int unsigned held_bytes = 0;
  bit          eos_known = 1'b0;
  logic [31:0] eos_pos = '0;

  out_item_t   awaited_results[$];

  initial begin
    errors      = 0;
    outstanding = 0;
    n_checked   = 0;
    n_pulled    = 0;
    n_dropped   = 0;
    done_seen   = 1'b0;
    for (int i = 0; i < WINDOW_DEPTH; i++) win_full[i] = 1'b0;
  end

  function automatic out_item_t reassemble(in_item_t it);
    out_item_t   r;
    logic [31:0] gap;
    int unsigned slot;
    bit          drop;
    r = '0;
    if (it.mode == MODE_PUSH) begin
      r.status = ST_STORED;
      if (it.has_byte) begin
        // distance wraps, so anything behind the read point looks far ahead
        gap = it.stream_index - rd_index;
        drop = (gap >= WINDOW_DEPTH) || (eos_known && gap >= eos_pos - rd_index);
        if (drop) begin
          r.status = ST_OUTSIDE;
        end else begin
          slot = (rd_slot + gap) % WINDOW_DEPTH;
          if (win_full[slot]) begin
            r.status = ST_DUP;
          end else begin
            win_data[slot] = it.byte_value;
            win_full[slot] = 1'b1;
            held_bytes++;
          end
        end
      end
      // first end marker wins, even when its byte is dropped
      if (it.end_of_stream && !eos_known) begin
        eos_known = 1'b1;
        eos_pos   = it.has_byte ? it.stream_index + 32'd1 : it.stream_index;
      end
    end else if (!(eos_known && rd_index == eos_pos) && win_full[rd_slot]) begin
      r.status       = ST_PULLED;
      r.out_valid    = 1'b1;
      r.out_byte     = win_data[rd_slot];
      win_full[rd_slot] = 1'b0;
      rd_slot        = (rd_slot + 1) % WINDOW_DEPTH;
      rd_index       = rd_index + 32'd1;
      if (held_bytes > 0) held_bytes--;
    end else begin
      r.status = ST_EMPTY;
    end
    r.pending_count = 13'(held_bytes);
    r.stream_done   = eos_known && rd_index == eos_pos;
    return r;
  endfunction

  task automatic report_field(string field, int unsigned want, int unsigned got);
    errors++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    if (!rst) begin
      // compare first so a result never matches an item taken at the same edge
      if (result_valid && result_ready) begin
        got = result;
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
        end else begin
          want = awaited_results.pop_front();
          n_checked++;
          if (got.status !== want.status) report_field("status", want.status, got.status);
          if (got.out_valid !== want.out_valid)
            report_field("out_valid", want.out_valid, got.out_valid);
          if (got.out_byte !== want.out_byte)
            report_field("out_byte", want.out_byte, got.out_byte);
          if (got.pending_count !== want.pending_count)
            report_field("pending_count", want.pending_count, got.pending_count);
          if (got.stream_done !== want.stream_done)
            report_field("stream_done", want.stream_done, got.stream_done);
        end
      end
      if (item_valid && item_ready) begin
        want = reassemble(item);
        awaited_results.push_back(want);
        if (want.status == ST_PULLED) n_pulled++;
        if (want.status == ST_DUP || want.status == ST_OUTSIDE) n_dropped++;
        if (want.stream_done) done_seen = 1'b1;
      end
      outstanding = awaited_results.size();
    end
  end

endmodule

// ----- bench/tb_byte_stream_reassembler.sv -----
// Top of the byte stream reassembler bench: clock, reset, item and result stimulus,
// watchdog and verdict. Depends on bsr_pkg, the block and bsr_stream_checker.
module tb_byte_stream_reassembler
  import bsr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 4096;
  localparam int RANDOM_END   = 1370;
  localparam int STALL_AT     = 400;
  localparam int STALL_CYCLES = 400;
  localparam int QUIET_LIMIT  = 20000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  int   fail_count;
  int   outstanding;
  int   n_checked;
  int   n_pulled;
  int   n_dropped;
  logic done_seen;

  int   sent = 0;
  int   quiet_cycles = 0;
  bit   calm = 1'b0;
  bit   tx_noisy = 1'b1;
  bit   rx_noisy = 1'b1;
  bit   stall_req = 1'b0;

  // Stream position the next successful pull will hand out, kept for aiming pushes
  logic [31:0] gen_next = '0;
  bit          filled [logic [31:0]];

  byte_stream_reassembler #(.WINDOW_DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  bsr_stream_checker #(.WINDOW_DEPTH(DEPTH)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .errors       (fail_count),
    .outstanding  (outstanding),
    .n_checked    (n_checked),
    .n_pulled     (n_pulled),
    .n_dropped    (n_dropped),
    .done_seen    (done_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("** byte_stream_reassembler: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: short random hold-offs, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (stall_req) begin
        result_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        result_ready <= 1'b1;
        stall_req = 1'b0;
      end else if (!calm && rx_noisy && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
      if ($urandom_range(0, 39) == 0) rx_noisy = !rx_noisy;
    end
  end

  task automatic offer(input in_item_t it);
    if (!calm && tx_noisy && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_ready !== 1'b1);
    sent++;
    if ($urandom_range(0, 49) == 0) tx_noisy = !tx_noisy;
  endtask

  task automatic push(input logic [31:0] idx, input logic [7:0] value, input logic has,
                      input logic eos);
    in_item_t it;
    it.mode          = MODE_PUSH;
    it.byte_value    = value;
    it.stream_index  = idx;
    it.has_byte      = has;
    it.end_of_stream = eos;
    if (has && (idx - gen_next) < DEPTH) filled[idx] = 1'b1;
    offer(it);
  endtask

  // Fill the fields a pull ignores with junk
  task automatic pull();
    in_item_t it;
    it.mode          = MODE_PULL;
    it.byte_value    = 8'($urandom);
    it.stream_index  = $urandom;
    it.has_byte      = 1'($urandom);
    it.end_of_stream = 1'($urandom);
    if (filled.exists(gen_next)) begin
      filled.delete(gen_next);
      gen_next = gen_next + 32'd1;
    end
    offer(it);
  endtask

  initial begin : stimulus
    int unsigned order [16];
    int unsigned run_len;
    int unsigned pick;
    int unsigned j;
    int unsigned tmp;
    logic [31:0] base;
    bit          stall_issued;
    stall_issued = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty pull, duplicates, window edges, wrapped index, empty push
    pull();
    push(32'd0, 8'h00, 1'b1, 1'b0);
    push(32'd0, 8'hFF, 1'b1, 1'b0);
    push(DEPTH - 1, 8'hA5, 1'b1, 1'b0);
    push(DEPTH, 8'h3C, 1'b1, 1'b0);
    push(32'hFFFF_FFFF, 8'h5A, 1'b1, 1'b0);
    push($urandom, 8'hFF, 1'b0, 1'b0);
    push(32'd1, 8'hFF, 1'b1, 1'b0);
    push(32'd2, 8'h81, 1'b1, 1'b0);
    repeat (4) pull();
    push(32'd0, 8'h11, 1'b1, 1'b0);
    push(32'd3, 8'h7E, 1'b1, 1'b0);
    pull();

    while (sent < RANDOM_END) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // a run of neighbouring bytes in shuffled order, some resent, then drained
        run_len = $urandom_range(1, 16);
        base = gen_next + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0);
        for (int k = 0; k < run_len; k++) order[k] = k;
        for (int k = run_len - 1; k > 0; k--) begin
          j        = $urandom_range(0, k);
          tmp      = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        for (int k = 0; k < run_len; k++) begin
          push(base + order[k], 8'($urandom), 1'b1, 1'b0);
          if ($urandom_range(0, 5) == 0)
            push(base + order[$urandom_range(0, k)], 8'($urandom), 1'b1, 1'b0);
          if ($urandom_range(0, 4) == 0) pull();
        end
        repeat (run_len + $urandom_range(0, 2)) pull();
      end else if (pick < 80) begin
        push(gen_next - $urandom_range(1, 64), 8'($urandom), 1'b1, 1'b0);
      end else if (pick < 86) begin
        push(gen_next + DEPTH - $urandom_range(0, 1), 8'($urandom), 1'b1, 1'b0);
      end else if (pick < 92) begin
        push($urandom, 8'($urandom), 1'($urandom), 1'b0);
      end else if (pick < 96) begin
        push($urandom, 8'($urandom), 1'b0, 1'b0);
      end else begin
        pull();
      end
      if (!stall_issued && sent >= STALL_AT) begin
        stall_req    = 1'b1;
        stall_issued = 1'b1;
      end
      if (sent >= RANDOM_END - 200) calm = 1'b1;
    end

    // Close the stream: end marker inside a stored run, then bytes past it,
    // repeated end markers, and a pull at the end with a byte still stored there
    base = gen_next;
    for (int k = 0; k < 10; k++) order[k] = k;
    for (int k = 9; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < 10; k++) push(base + order[k], 8'($urandom), 1'b1, 1'b0);
    push(base + 5, 8'($urandom), 1'b0, 1'b1);
    push(base + 7, 8'($urandom), 1'b1, 1'b0);
    push(base + 12, 8'($urandom), 1'b1, 1'b0);
    push(base + 2, 8'($urandom), 1'b1, 1'b1);
    push(base + 40, 8'($urandom), 1'b0, 1'b1);
    push(32'hFFFF_FFFF, 8'($urandom), 1'b1, 1'b1);
    repeat (6) pull();
    push(base + 5, 8'($urandom), 1'b1, 1'b0);
    item_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Covered %0d transactions in, %0d results checked: %0d bytes handed out in order,",
             sent, n_checked, n_pulled);
    $display("%0d pushes dropped as duplicate or outside the window, end of stream reached: %0d",
             n_dropped, done_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** byte_stream_reassembler: PASSED **");
    end else begin
      $display("** byte_stream_reassembler: FAILED **");
    end
    $finish;
  end

endmodule
